@@ hw/rtl/lps_pkg.sv @@
package lps_pkg;

  // default coordinate width
  localparam int unsigned CoordBitsDefault = 10;

  // request codes
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqStep = 1'b1;

  // line walking modes
  localparam logic [1:0] ModeIdle     = 2'd0;
  localparam logic [1:0] ModeVertical = 2'd1;
  localparam logic [1:0] ModeWalk     = 2'd2;

  // control from the input stage to the engine
  typedef struct packed {
    logic go;
    logic is_load;
  } lps_ctl_t;

endpackage

@@ hw/rtl/lps_req_if.sv @@
interface lps_req_if #(
  parameter int unsigned CoordBits = lps_pkg::CoordBitsDefault
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [CoordBits-1:0] start_x;
  logic [CoordBits-1:0] start_y;
  logic [CoordBits-1:0] end_x;
  logic [CoordBits-1:0] end_y;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ hw/rtl/lps_pt_if.sv @@
interface lps_pt_if #(
  parameter int unsigned CoordBits = lps_pkg::CoordBitsDefault
);
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] point_x;
  logic [CoordBits-1:0] point_y;
  logic                 has_point;
  logic                 last_point;

  modport source (output valid, point_x, point_y, has_point, last_point, input ready);
  modport sink (input valid, point_x, point_y, has_point, last_point, output ready);
endinterface

@@ hw/rtl/line_point_stepper_unit.sv @@
// a step word gives its point word through the input register and then the point register
// one word per cycle unless the point register is stalled; the line state updates in a single pass
// through the step logic between the input register and the point register
// a load word updates the line state and gives no point word
// reset (async, active low) empties both registers and leaves no line loaded
module line_point_stepper_unit #(
  parameter int unsigned CoordBits = lps_pkg::CoordBitsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lps_req_if.sink  req_i,
  lps_pt_if.source pt_o
);

  logic                 in_vld_q, in_vld_d;
  logic                 in_type_q;
  logic [CoordBits-1:0] in_sx_q, in_sy_q, in_ex_q, in_ey_q;
  logic                 out_vld_q, out_vld_d;
  logic [CoordBits-1:0] out_x_q, out_y_q;
  logic                 out_has_q, out_last_q;
  logic                 out_free, advance, in_take, out_load;
  lps_pkg::lps_ctl_t    ctl;
  logic [CoordBits-1:0] res_x, res_y;
  logic                 res_has, res_last;

  // handshake between the two registers
  always_comb begin
    out_free    = !out_vld_q || pt_o.ready;
    advance     = in_vld_q && ((in_type_q == lps_pkg::ReqLoad) || out_free);
    req_i.ready = !in_vld_q || advance;
    in_take     = req_i.valid && req_i.ready;
    in_vld_d    = in_take || (in_vld_q && !advance);
    out_load    = advance && (in_type_q == lps_pkg::ReqStep);
    out_vld_d   = out_load || (out_vld_q && !pt_o.ready);
    ctl.go      = advance;
    ctl.is_load = (in_type_q == lps_pkg::ReqLoad);
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_type_q <= req_i.req_type;
      in_sx_q   <= req_i.start_x;
      in_sy_q   <= req_i.start_y;
      in_ex_q   <= req_i.end_x;
      in_ey_q   <= req_i.end_y;
    end
  end

  lps_engine #(
    .CoordBits(CoordBits)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .start_x_i   (in_sx_q),
    .start_y_i   (in_sy_q),
    .end_x_i     (in_ex_q),
    .end_y_i     (in_ey_q),
    .point_x_o   (res_x),
    .point_y_o   (res_y),
    .has_point_o (res_has),
    .last_point_o(res_last)
  );

  // point register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= res_x;
      out_y_q    <= res_y;
      out_has_q  <= res_has;
      out_last_q <= res_last;
    end
  end

  assign pt_o.valid      = out_vld_q;
  assign pt_o.point_x    = out_x_q;
  assign pt_o.point_y    = out_y_q;
  assign pt_o.has_point  = out_has_q;
  assign pt_o.last_point = out_last_q;

endmodule

@@ hw/rtl/lps_engine.sv @@
module lps_engine #(
  parameter int unsigned CoordBits = lps_pkg::CoordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lps_pkg::lps_ctl_t    ctl_i,
  input  logic [CoordBits-1:0] start_x_i,
  input  logic [CoordBits-1:0] start_y_i,
  input  logic [CoordBits-1:0] end_x_i,
  input  logic [CoordBits-1:0] end_y_i,
  output logic [CoordBits-1:0] point_x_o,
  output logic [CoordBits-1:0] point_y_o,
  output logic                 has_point_o,
  output logic                 last_point_o
);

  localparam int unsigned N   = CoordBits;
  localparam int unsigned DxW = N + 2;  // 2*dx, unsigned
  localparam int unsigned DyW = N + 3;  // 2*dy, signed
  localparam int unsigned EW  = N + 4;  // decision error, signed
  localparam int unsigned CW  = N + 5;  // doubled error for compares

  logic [N-1:0]          cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [N-1:0]          far_x_q, far_x_d, far_y_q, far_y_d;
  logic signed [EW-1:0]  err_q, err_d;
  logic [DxW-1:0]        tdx_q, tdx_d;
  logic signed [DyW-1:0] tdy_q, tdy_d;
  logic [1:0]            mode_q, mode_d;

  // true when a and b differ by at most one
  function automatic logic within_one(input logic [N:0] a, input logic [N:0] b);
    logic [N:0] a1, b1;
    a1 = a + {{N{1'b0}}, 1'b1};
    b1 = b + {{N{1'b0}}, 1'b1};
    return (a == b) || (a1 == b) || (b1 == a);
  endfunction

  // load side: order the endpoints
  logic          ld_vert, ld_swap;
  logic [N-1:0]  ld_sx, ld_sy, ld_fx, ld_fy, ld_ylo, ld_yhi, ld_span;
  logic          ld_near;

  always_comb begin
    ld_vert = (start_x_i == end_x_i);
    ld_swap = (end_x_i < start_x_i);
    ld_sx   = ld_swap ? end_x_i : start_x_i;
    ld_sy   = ld_swap ? end_y_i : start_y_i;
    ld_fx   = ld_swap ? start_x_i : end_x_i;
    ld_fy   = ld_swap ? start_y_i : end_y_i;
    ld_ylo  = (start_y_i < end_y_i) ? start_y_i : end_y_i;
    ld_yhi  = (start_y_i < end_y_i) ? end_y_i : start_y_i;
    ld_span = ld_yhi - ld_ylo;
    ld_near = within_one({1'b0, ld_sx}, {1'b0, ld_fx}) &&
              within_one({1'b0, ld_sy}, {1'b0, ld_fy});
  end

  // step side: compares and increments
  logic [N:0]            vy1, vy2;
  logic signed [CW-1:0]  e2, tdx_s;
  logic                  w_up, w_down, w_near;
  logic [N:0]            wx1;
  logic [N-1:0]          diff_x;

  always_comb begin
    vy1    = {1'b0, cur_y_q} + {{N{1'b0}}, 1'b1};
    vy2    = vy1 + {{N{1'b0}}, 1'b1};
    e2     = {err_q, 1'b0};
    tdx_s  = signed'({3'b000, tdx_q});
    w_up   = (e2 > tdx_s);
    w_down = (e2 < -tdx_s);
    wx1    = {1'b0, cur_x_q} + {{N{1'b0}}, 1'b1};
    w_near = within_one(wx1, {1'b0, far_x_q}) &&
             within_one({1'b0, cur_y_q}, {1'b0, far_y_q});
    diff_x = ld_fx - ld_sx;
  end

  // next state and result
  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    far_x_d      = far_x_q;
    far_y_d      = far_y_q;
    err_d        = err_q;
    tdx_d        = tdx_q;
    tdy_d        = tdy_q;
    mode_d       = mode_q;
    point_x_o    = '0;
    point_y_o    = '0;
    has_point_o  = 1'b0;
    last_point_o = 1'b0;
    if (ctl_i.go && ctl_i.is_load) begin
      err_d = '0;
      if (ld_vert) begin
        cur_x_d = start_x_i;
        cur_y_d = ld_ylo;
        far_x_d = start_x_i;
        far_y_d = ld_yhi;
        tdx_d   = '0;
        tdy_d   = '0;
        mode_d  = (ld_span > {{(N-1){1'b0}}, 1'b1}) ? lps_pkg::ModeVertical
                                                    : lps_pkg::ModeIdle;
      end else begin
        cur_x_d = ld_sx;
        cur_y_d = ld_sy;
        far_x_d = ld_fx;
        far_y_d = ld_fy;
        tdx_d   = {1'b0, diff_x, 1'b0};
        tdy_d   = ({3'b000, ld_fy} - {3'b000, ld_sy}) <<< 1;
        mode_d  = ld_near ? lps_pkg::ModeIdle : lps_pkg::ModeWalk;
      end
    end else if (ctl_i.go) begin
      unique case (mode_q)
        lps_pkg::ModeVertical: begin
          if (vy1 < {1'b0, far_y_q}) begin
            cur_y_d      = vy1[N-1:0];
            point_x_o    = cur_x_q;
            point_y_o    = vy1[N-1:0];
            has_point_o  = 1'b1;
            last_point_o = (vy2 >= {1'b0, far_y_q});
            if (vy2 >= {1'b0, far_y_q}) begin
              mode_d = lps_pkg::ModeIdle;
            end
          end else begin
            mode_d = lps_pkg::ModeIdle;
          end
        end
        lps_pkg::ModeWalk: begin
          has_point_o = 1'b1;
          point_x_o   = cur_x_q;
          if (w_up) begin
            cur_y_d   = cur_y_q + {{(N-1){1'b0}}, 1'b1};
            err_d     = err_q - signed'({2'b00, tdx_q});
            point_y_o = cur_y_d;
          end else if (w_down) begin
            cur_y_d   = cur_y_q - {{(N-1){1'b0}}, 1'b1};
            err_d     = err_q + signed'({2'b00, tdx_q});
            point_y_o = cur_y_d;
          end else begin
            err_d        = err_q + EW'(tdy_q);
            cur_x_d      = wx1[N-1:0];
            point_y_o    = cur_y_q;
            last_point_o = w_near;
            if (w_near) begin
              mode_d = lps_pkg::ModeIdle;
            end
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      far_x_q <= '0;
      far_y_q <= '0;
      err_q   <= '0;
      tdx_q   <= '0;
      tdy_q   <= '0;
      mode_q  <= lps_pkg::ModeIdle;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      far_x_q <= far_x_d;
      far_y_q <= far_y_d;
      err_q   <= err_d;
      tdx_q   <= tdx_d;
      tdy_q   <= tdy_d;
      mode_q  <= mode_d;
    end
  end

endmodule

@@ hw/rtl/lps_checker.sv @@
module lps_checker #(
  parameter int unsigned CoordBits = lps_pkg::CoordBitsDefault
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_ready_i,
  input logic                 pt_valid_i,
  input logic                 pt_ready_i,
  input logic [CoordBits-1:0] point_x_i,
  input logic [CoordBits-1:0] point_y_i,
  input logic                 has_point_i,
  input logic                 last_point_i
);

  // an empty word carries zero coordinates and no last mark
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_valid_i && !has_point_i) |-> (point_x_i == '0 && point_y_i == '0 && !last_point_i))
    else $error("empty point word carries data");

  // the last mark only comes with a point
  a_last_has_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_valid_i && last_point_i) |-> has_point_i)
    else $error("last mark without a point");

  // with the point register empty the input side is always open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pt_valid_i |-> req_ready_i)
    else $error("request stalled with empty point register");

  // a stalled point word stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_valid_i && !pt_ready_i) |=> pt_valid_i)
    else $error("point word dropped while stalled");

  // a stalled point word keeps its payload
  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_valid_i && !pt_ready_i) |=>
      ($stable(point_x_i) && $stable(point_y_i) && $stable(has_point_i) &&
       $stable(last_point_i)))
    else $error("point word changed while stalled");

endmodule

bind line_point_stepper_unit lps_checker #(
  .CoordBits(CoordBits)
) u_lps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .pt_valid_i  (pt_o.valid),
  .pt_ready_i  (pt_o.ready),
  .point_x_i   (pt_o.point_x),
  .point_y_i   (pt_o.point_y),
  .has_point_i (pt_o.has_point),
  .last_point_i(pt_o.last_point)
);

@@ bench/tb_line_point_stepper_unit.sv @@
`timescale 1ns / 1ps

module tb_line_point_stepper_unit;

  localparam int CoordBits = lps_pkg::CoordBitsDefault;
  localparam int CoordMax  = (1 << CoordBits) - 1;

  typedef struct {
    logic                 req_type;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
  } line_word_t;

  typedef struct {
    logic [CoordBits-1:0] point_x;
    logic [CoordBits-1:0] point_y;
    logic                 has_point;
    logic                 last_point;
  } point_t;

  logic clk_i;
  logic rst_ni;

  lps_req_if #(.CoordBits(CoordBits)) req_bus ();
  lps_pt_if  #(.CoordBits(CoordBits)) pt_bus ();

  line_point_stepper_unit #(.CoordBits(CoordBits)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .pt_o   (pt_bus)
  );

  // words waiting to be sent and points the line walk should produce
  line_word_t words_to_send[$];
  point_t     points_due[$];

  int words_accepted = 0;
  int words_taken    = 0;
  int points_seen    = 0;
  int lit_points     = 0;
  int line_ends      = 0;
  int fail_cnt       = 0;

  // shadow of the line walk state
  int         ln_cur_x = 0, ln_cur_y = 0, ln_far_x = 0, ln_far_y = 0;
  int         ln_err = 0, ln_twice_dx = 0, ln_twice_dy = 0;
  logic [1:0] ln_mode = lps_pkg::ModeIdle;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // within one unit of the far endpoint on both axes
  function automatic bit near_far_end(int cx, int cy);
    return abs_int(cx - ln_far_x) <= 1 && abs_int(cy - ln_far_y) <= 1;
  endfunction

  // advance the shadow line walk by one accepted word
  task automatic step_line(input line_word_t w);
    point_t p;
    int     ny;
    if (w.req_type == lps_pkg::ReqLoad) begin
      ln_err = 0;
      if (w.start_x == w.end_x) begin
        ln_cur_x    = int'(w.start_x);
        ln_cur_y    = (w.start_y < w.end_y) ? int'(w.start_y) : int'(w.end_y);
        ln_far_x    = int'(w.start_x);
        ln_far_y    = (w.start_y < w.end_y) ? int'(w.end_y) : int'(w.start_y);
        ln_twice_dx = 0;
        ln_twice_dy = 0;
        ln_mode     = (ln_far_y - ln_cur_y > 1) ? lps_pkg::ModeVertical
                                                : lps_pkg::ModeIdle;
      end else begin
        if (w.start_x < w.end_x) begin
          ln_cur_x = int'(w.start_x); ln_cur_y = int'(w.start_y);
          ln_far_x = int'(w.end_x);   ln_far_y = int'(w.end_y);
        end else begin
          ln_cur_x = int'(w.end_x);   ln_cur_y = int'(w.end_y);
          ln_far_x = int'(w.start_x); ln_far_y = int'(w.start_y);
        end
        ln_twice_dx = 2 * (ln_far_x - ln_cur_x);
        ln_twice_dy = 2 * (ln_far_y - ln_cur_y);
        ln_mode     = near_far_end(ln_cur_x, ln_cur_y) ? lps_pkg::ModeIdle
                                                       : lps_pkg::ModeWalk;
      end
      return;
    end
    p.point_x    = '0;
    p.point_y    = '0;
    p.has_point  = 1'b0;
    p.last_point = 1'b0;
    case (ln_mode)
      lps_pkg::ModeVertical: begin
        ny = ln_cur_y + 1;
        if (ny < ln_far_y) begin
          ln_cur_y     = ny & CoordMax;
          p.point_x    = CoordBits'(ln_cur_x);
          p.point_y    = CoordBits'(ln_cur_y);
          p.has_point  = 1'b1;
          p.last_point = (ny + 1 >= ln_far_y);
          if (p.last_point) ln_mode = lps_pkg::ModeIdle;
        end else begin
          ln_mode = lps_pkg::ModeIdle;
        end
      end
      lps_pkg::ModeWalk: begin
        p.has_point = 1'b1;
        if (2 * ln_err > ln_twice_dx) begin
          // y move up toward the ideal line
          ln_cur_y  = (ln_cur_y + 1) & CoordMax;
          ln_err   -= ln_twice_dx;
          p.point_x = CoordBits'(ln_cur_x);
          p.point_y = CoordBits'(ln_cur_y);
        end else if (2 * ln_err < -ln_twice_dx) begin
          // y move down toward the ideal line
          ln_cur_y  = (ln_cur_y - 1) & CoordMax;
          ln_err   += ln_twice_dx;
          p.point_x = CoordBits'(ln_cur_x);
          p.point_y = CoordBits'(ln_cur_y);
        end else begin
          // column point, then x advances
          p.point_x = CoordBits'(ln_cur_x);
          p.point_y = CoordBits'(ln_cur_y);
          ln_err   += ln_twice_dy;
          if (near_far_end(ln_cur_x + 1, ln_cur_y)) begin
            ln_mode      = lps_pkg::ModeIdle;
            p.last_point = 1'b1;
          end
          ln_cur_x = (ln_cur_x + 1) & CoordMax;
        end
      end
      default: ;
    endcase
    points_due = {points_due, p};
  endtask

  task automatic add_load(input int ax, input int ay, input int bx, input int by);
    line_word_t w;
    w.req_type = lps_pkg::ReqLoad;
    w.start_x  = CoordBits'(ax);
    w.start_y  = CoordBits'(ay);
    w.end_x    = CoordBits'(bx);
    w.end_y    = CoordBits'(by);
    words_to_send = {words_to_send, w};
  endtask

  // step words carry random coordinates that the block must ignore
  task automatic add_steps(input int n);
    line_word_t w;
    repeat (n) begin
      w.req_type = lps_pkg::ReqStep;
      w.start_x  = CoordBits'($urandom_range(CoordMax));
      w.start_y  = CoordBits'($urandom_range(CoordMax));
      w.end_x    = CoordBits'($urandom_range(CoordMax));
      w.end_y    = CoordBits'($urandom_range(CoordMax));
      words_to_send = {words_to_send, w};
    end
  endtask

  // no idling on either side for a stretch in the middle of the run
  function automatic bit steady_stretch();
    return words_accepted >= 200 && words_accepted < 320;
  endfunction

  // driver: a word stays up until taken, gaps only between words
  always @(negedge clk_i) begin : drive_words
    line_word_t w;
    bit         waiting;
    if (!rst_ni) begin
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= lps_pkg::ReqLoad;
      req_bus.start_x  <= '0;
      req_bus.start_y  <= '0;
      req_bus.end_x    <= '0;
      req_bus.end_y    <= '0;
      pt_bus.ready     <= 1'b0;
    end else begin
      waiting = req_bus.valid && (words_accepted == words_taken);
      if (!waiting) begin
        words_taken = words_accepted;
        if (words_to_send.size() != 0 &&
            (steady_stretch() || $urandom_range(99) >= 28)) begin
          w = words_to_send.pop_front();
          req_bus.req_type <= w.req_type;
          req_bus.start_x  <= w.start_x;
          req_bus.start_y  <= w.start_y;
          req_bus.end_x    <= w.end_x;
          req_bus.end_y    <= w.end_y;
          req_bus.valid    <= 1'b1;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
      pt_bus.ready <= steady_stretch() || ($urandom_range(99) >= 28);
    end
  end

  // monitor: check the point word taken at this edge, then predict from the request word
  always @(posedge clk_i) begin : check_points
    point_t     want;
    line_word_t w;
    if (rst_ni) begin
      if (pt_bus.valid && pt_bus.ready) begin
        points_seen++;
        if (pt_bus.has_point)  lit_points++;
        if (pt_bus.last_point) line_ends++;
        if (points_due.size() == 0) begin
          $error("point word with none expected: x %0d y %0d has %0b last %0b",
                 pt_bus.point_x, pt_bus.point_y, pt_bus.has_point, pt_bus.last_point);
          fail_cnt++;
        end else begin
          want = points_due.pop_front();
          if (pt_bus.point_x !== want.point_x) begin
            $error("point_x expected %0d actual %0d", want.point_x, pt_bus.point_x);
            fail_cnt++;
          end
          if (pt_bus.point_y !== want.point_y) begin
            $error("point_y expected %0d actual %0d", want.point_y, pt_bus.point_y);
            fail_cnt++;
          end
          if (pt_bus.has_point !== want.has_point) begin
            $error("has_point expected %0b actual %0b", want.has_point, pt_bus.has_point);
            fail_cnt++;
          end
          if (pt_bus.last_point !== want.last_point) begin
            $error("last_point expected %0b actual %0b", want.last_point, pt_bus.last_point);
            fail_cnt++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        w.req_type = req_bus.req_type;
        w.start_x  = req_bus.start_x;
        w.start_y  = req_bus.start_y;
        w.end_x    = req_bus.end_x;
        w.end_y    = req_bus.end_y;
        step_line(w);
        words_accepted++;
      end
    end
  end

  // run limit
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int sx, sy, ex, ey, dx, dy, n, pick;

    rst_ni = 1'b0;

    // directed: step with no line loaded
    add_steps(1);
    // vertical line at the top corner, interior points then finished
    add_load(CoordMax, CoordMax, CoordMax, CoordMax - 3);
    add_steps(3);
    // vertical line spanning one unit gives nothing
    add_load(0, 0, 0, 1);
    add_steps(1);
    // endpoints within one unit
    add_load(0, 0, 1, 1);
    add_steps(1);
    // shallow line rising from the origin
    add_load(0, 0, 3, 2);
    add_steps(5);
    // steep line falling, walked from the far endpoint with lower x
    add_load(2, 0, 0, 3);
    add_steps(5);
    // full diagonal, replaced by a horizontal line before it ends
    add_load(0, 0, CoordMax, CoordMax);
    add_steps(2);
    add_load(CoordMax, 0, CoordMax - 4, 0);
    add_steps(4);

    // random: mostly short lines walked to the end, some long ones cut off, some noise
    while (words_to_send.size() < 550) begin
      pick = int'($urandom_range(99));
      if (pick < 80) begin
        sx = int'($urandom_range(CoordMax));
        sy = int'($urandom_range(CoordMax));
        dx = int'($urandom_range(24)) - 12;
        dy = int'($urandom_range(24)) - 12;
        if ($urandom_range(9) == 0) dx = 0;
        ex = sx + dx;
        if (ex < 0 || ex > CoordMax) ex = sx - dx;
        ey = sy + dy;
        if (ey < 0 || ey > CoordMax) ey = sy - dy;
        add_load(sx, sy, ex, ey);
        n = abs_int(dx) + abs_int(dy) + 1 + int'($urandom_range(2));
        if ($urandom_range(7) == 0) n = int'($urandom_range(n));
        add_steps(n);
      end else if (pick < 88) begin
        add_load(int'($urandom_range(CoordMax)), int'($urandom_range(CoordMax)),
                 int'($urandom_range(CoordMax)), int'($urandom_range(CoordMax)));
        add_steps(int'($urandom_range(15, 2)));
      end else if (pick < 94) begin
        add_steps(int'($urandom_range(3, 1)));
      end else begin
        add_load(int'($urandom_range(CoordMax)), int'($urandom_range(CoordMax)),
                 int'($urandom_range(CoordMax)), int'($urandom_range(CoordMax)));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_to_send.size() != 0 || req_bus.valid || points_due.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d request words: %0d point words checked, %0d raster points",
             words_accepted, points_seen, lit_points);
    $display("%0d lines walked to their end marker, %0d mismatches", line_ends, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ line_point_stepper_unit.f @@
hw/rtl/lps_pkg.sv
hw/rtl/lps_req_if.sv
hw/rtl/lps_pt_if.sv
hw/rtl/lps_engine.sv
hw/rtl/line_point_stepper_unit.sv
hw/rtl/lps_checker.sv
bench/tb_line_point_stepper_unit.sv
